// ===== hw/rtl/rlee_pkg.sv =====
// Shared types, constants and helpers for the escape-byte run-length encoder.
package rlee_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] RUN_CAP           = 8'd255;
   localparam logic [2:0] MIN_RUN_LIMIT     = 3'd4;
   localparam logic [7:0] ESCAPE_MARKER_RST = 8'hFF;
   localparam logic [2:0] MIN_RUN_RST       = 3'd3;

   typedef enum logic [0:0] {
      CSR_ESCAPE_MARKER = 1'b0,
      CSR_MIN_RUN       = 1'b1
   } rlee_csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } rlee_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       item_done;
      logic       buffer_done;
   } rlee_rsp_type;

   typedef struct packed {
      logic       valid;
      logic       triple;
      logic [7:0] length;
      logic [7:0] value;
   } rlee_flush_type;

   typedef struct packed {
      rlee_flush_type flush_a;
      rlee_flush_type flush_b;
      logic           last_byte;
   } rlee_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } rlee_qstat_type;

   function automatic logic [2:0] rlee_eff_min(input logic [2:0] min_run);
      logic [2:0] m;
      m = min_run;
      if (m == 3'd0) begin
         m = 3'd1;
      end
      if (m > MIN_RUN_LIMIT) begin
         m = MIN_RUN_LIMIT;
      end
      return m;
   endfunction

   function automatic logic rlee_is_triple(input logic [7:0] length,
                                           input logic [7:0] value,
                                           input logic [7:0] marker,
                                           input logic [2:0] min_run);
      return (length >= {5'd0, rlee_eff_min(min_run)}) || (value == marker);
   endfunction

endpackage

// ===== hw/rtl/rlee_front.sv =====
// Front end: accepts bytes, tracks the pending run and issues flush commands.
module rlee_front import rlee_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  rlee_req_type   req_data,
   input  logic [7:0]     escape_marker,
   input  logic [2:0]     min_run,
   input  rlee_qstat_type q_stat,
   output logic           q_push,
   output rlee_cmd_type   q_cmd
);

   logic [7:0] run_value_ff, run_value_in;
   logic [7:0] run_length_ff, run_length_in;
   logic [7:0] val_nx, len_nx;
   logic       accept, flush_a_go, flush_b_go;

   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      flush_a_go = (run_length_ff != 8'd0) && (req_data.data_byte != run_value_ff);
      if ((run_length_ff == 8'd0) || flush_a_go) begin
         val_nx = req_data.data_byte;
         len_nx = 8'd1;
      end else begin
         val_nx = run_value_ff;
         len_nx = run_length_ff + 8'd1;
      end
      flush_b_go = (len_nx == RUN_CAP) || req_data.last_byte;

      q_cmd.flush_a.valid  = flush_a_go;
      q_cmd.flush_a.triple = rlee_is_triple(run_length_ff, run_value_ff, escape_marker,
                                            min_run);
      q_cmd.flush_a.length = run_length_ff;
      q_cmd.flush_a.value  = run_value_ff;
      q_cmd.flush_b.valid  = flush_b_go;
      q_cmd.flush_b.triple = rlee_is_triple(len_nx, val_nx, escape_marker, min_run);
      q_cmd.flush_b.length = len_nx;
      q_cmd.flush_b.value  = val_nx;
      q_cmd.last_byte      = req_data.last_byte;

      q_push = accept && (flush_a_go || flush_b_go);

      run_value_in  = run_value_ff;
      run_length_in = run_length_ff;
      if (accept) begin
         if (flush_b_go) begin
            run_value_in  = 8'd0;
            run_length_in = 8'd0;
         end else begin
            run_value_in  = val_nx;
            run_length_in = len_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_value_ff  <= 8'd0;
         run_length_ff <= 8'd0;
      end else begin
         run_value_ff  <= run_value_in;
         run_length_ff <= run_length_in;
      end
   end

endmodule

// ===== hw/rtl/rlee_queue.sv =====
// Command queue between the front end and the byte emitter.
module rlee_queue import rlee_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  rlee_cmd_type   push_cmd,
   input  logic           pop,
   output rlee_cmd_type   head_cmd,
   output rlee_qstat_type stat
);

   rlee_cmd_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/rlee_back.sv =====
// Back end: expands flush commands into encoded bytes, one per cycle while the output is not stalled.
module rlee_back import rlee_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  rlee_cmd_type   head_cmd,
   input  rlee_qstat_type q_stat,
   output logic           q_pop,
   input  logic [7:0]     escape_marker,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rlee_rsp_type   rsp_data
);

   logic           phase_b_ff, phase_b_in;
   logic [1:0]     idx_ff, idx_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rlee_rsp_type   rsp_data_ff, rsp_data_in;
   rlee_flush_type cur;
   logic           sel_b, advance, last_of_flush, last_of_item;
   logic [1:0]     nbytes;
   logic [7:0]     byte_nx;

   always_comb begin
      sel_b  = phase_b_ff || !head_cmd.flush_a.valid;
      cur    = sel_b ? head_cmd.flush_b : head_cmd.flush_a;
      nbytes = cur.triple ? 2'd3 : cur.length[1:0];
      if (!cur.triple) begin
         byte_nx = cur.value;
      end else if (idx_ff == 2'd0) begin
         byte_nx = escape_marker;
      end else if (idx_ff == 2'd1) begin
         byte_nx = cur.length;
      end else begin
         byte_nx = cur.value;
      end
      last_of_flush = (idx_ff == nbytes - 2'd1);
      last_of_item  = last_of_flush && (sel_b || !head_cmd.flush_b.valid);
      advance       = !q_stat.empty && (!rsp_valid_ff || rsp_ready);
      q_pop         = advance && last_of_item;

      phase_b_in   = phase_b_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.out_byte    = byte_nx;
         rsp_data_in.item_done   = last_of_item;
         rsp_data_in.buffer_done = last_of_item && head_cmd.last_byte;
         if (last_of_item) begin
            phase_b_in = 1'b0;
            idx_in     = 2'd0;
         end else if (last_of_flush) begin
            phase_b_in = 1'b1;
            idx_in     = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_b_ff   <= 1'b0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_b_ff   <= phase_b_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/rle_escape_encoder_unit.sv =====
// Top level of the escape-byte run-length encoder.
// The encoder takes one input byte per cycle while its four-entry command queue has room,
// and sends encoded bytes at one per cycle, while the receiver takes them, from a
// registered output stage; an item yields zero to six bytes (a literal burst of up to
// three, or a marker/count/value triple, for each of up to two flushed runs). Input rate
// is one item per cycle as long as the encoded stream averages at most one byte per item;
// bursts are held in the queue and the output register, and when the queue fills the
// input stalls until the emitter drains an entry. Reset needs no clearing pass.
module rle_escape_encoder_unit import rlee_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  rlee_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rlee_rsp_type rsp_data,
   input  logic         csr_we,
   input  logic [0:0]   csr_index,
   input  logic [7:0]   csr_wdata
);

   logic [7:0]     escape_marker_ff, escape_marker_in;
   logic [2:0]     min_run_ff, min_run_in;
   rlee_qstat_type q_stat;
   rlee_cmd_type   push_cmd, head_cmd;
   logic           q_push, q_pop;

   always_comb begin
      escape_marker_in = escape_marker_ff;
      min_run_in       = min_run_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ESCAPE_MARKER: begin
               escape_marker_in = csr_wdata;
            end
            CSR_MIN_RUN: begin
               min_run_in = csr_wdata[2:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_marker_ff <= ESCAPE_MARKER_RST;
         min_run_ff       <= MIN_RUN_RST;
      end else begin
         escape_marker_ff <= escape_marker_in;
         min_run_ff       <= min_run_in;
      end
   end

   rlee_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .escape_marker (escape_marker_ff),
      .min_run       (min_run_ff),
      .q_stat        (q_stat),
      .q_push        (q_push),
      .q_cmd         (push_cmd)
   );

   rlee_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .stat     (q_stat)
   );

   rlee_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_cmd      (head_cmd),
      .q_stat        (q_stat),
      .q_pop         (q_pop),
      .escape_marker (escape_marker_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data)
   );

   a_buffer_done_ends_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.buffer_done |-> rsp_data.item_done)
      else $error("buffer_done without item_done");

   a_queue_stat_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue both full and empty");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !q_push)
      else $error("command pushed into full queue");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("pop from empty queue");

endmodule
